@@ design/cpc_pkg.sv @@
package cpc_pkg;

   // square root chain: radicand is the squared distance scaled by 2^20
   localparam int RadicandW = 62;
   localparam int RootW     = 31;
   localparam int RemW      = 33;

   localparam int SqrtCells    = 31;
   localparam int ContactCells = 24;
   localparam int NormalCells  = 15;
   localparam int ContactDw    = 22;
   localparam int NormalDw     = 32;

   // request data that rides along the square root chain
   typedef struct packed {
      logic        hit;
      logic        sx;
      logic        sy;
      logic [20:0] mx;
      logic [20:0] my;
      logic [20:0] r;
      logic        cneg_x;
      logic        cneg_y;
   } side_a_type;

   // request data that rides along the normal divider chain
   typedef struct packed {
      logic               hit;
      logic               sx;
      logic               sy;
      logic               nzero;
      logic [20:0]        depth;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
   } side_b_type;

endpackage

@@ design/cpc_sqrt_cell.sv @@
module cpc_sqrt_cell (
   input  logic                          clock,
   input  logic [cpc_pkg::RadicandW-1:0] src_rad,
   input  logic [cpc_pkg::RemW-1:0]      src_rem,
   input  logic [cpc_pkg::RootW-1:0]     src_root,
   output logic [cpc_pkg::RadicandW-1:0] dst_rad,
   output logic [cpc_pkg::RemW-1:0]      dst_rem,
   output logic [cpc_pkg::RootW-1:0]     dst_root
);
   import cpc_pkg::*;

   logic [RadicandW-1:0] rad_ff, rad_in;
   logic [RemW-1:0]      rem_ff, rem_in;
   logic [RootW-1:0]     root_ff, root_in;
   logic [RemW+1:0]      trial_rem;
   logic [RemW+1:0]      trial_sub;
   logic [RemW+1:0]      diff;
   logic                 take;

   // bring down the next two radicand bits and try the next root bit
   assign trial_rem = {src_rem, src_rad[RadicandW-1 -: 2]};
   assign trial_sub = {2'b00, src_root, 2'b01};
   assign take      = trial_rem >= trial_sub;
   assign diff      = trial_rem - trial_sub;

   always_comb begin
      rad_in  = {src_rad[RadicandW-3:0], 2'b00};
      rem_in  = take ? diff[RemW-1:0] : trial_rem[RemW-1:0];
      root_in = {src_root[RootW-2:0], take};
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign dst_rad  = rad_ff;
   assign dst_rem  = rem_ff;
   assign dst_root = root_ff;

endmodule

@@ design/cpc_div_cell.sv @@
module cpc_div_cell #(
   parameter int DW = 22,
   parameter int QW = 24
) (
   input  logic          clock,
   input  logic [DW-1:0] src_den,
   input  logic [DW-1:0] src_rem,
   input  logic [QW-1:0] src_low,
   input  logic [QW-1:0] src_quo,
   output logic [DW-1:0] dst_den,
   output logic [DW-1:0] dst_rem,
   output logic [QW-1:0] dst_low,
   output logic [QW-1:0] dst_quo
);
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] low_ff, low_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          take;

   // shift in the next numerator bit, subtract the divisor when it fits
   assign shifted = {src_rem, src_low[QW-1]};
   assign take    = shifted >= {1'b0, src_den};
   assign diff    = shifted - {1'b0, src_den};

   always_comb begin
      den_in = src_den;
      rem_in = take ? diff[DW-1:0] : shifted[DW-1:0];
      low_in = {src_low[QW-2:0], 1'b0};
      quo_in = {src_quo[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign dst_den = den_ff;
   assign dst_rem = rem_ff;
   assign dst_low = low_ff;
   assign dst_quo = quo_ff;

endmodule

@@ design/circle_pair_contact_core.sv @@
// A request taken at a clock edge shows its result on the rsp_ ports with rsp_valid
// high for one cycle. Throughput: one request per cycle while busy is low; busy is
// low except in reset. The pipeline depth is set by the front stages, the 31-cell
// square root chain, prep stage, 15-cell normal divider chain and output register.
// Reset clears the valid pipeline and holds busy high; the receiver cannot stall.
module circle_pair_contact_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_a_x,
   input  logic signed [23:0] req_a_y,
   input  logic [19:0]        req_a_radius,
   input  logic signed [23:0] req_b_x,
   input  logic signed [23:0] req_b_y,
   input  logic [19:0]        req_b_radius,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [23:0] rsp_contact_x,
   output logic signed [23:0] rsp_contact_y,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [20:0]        rsp_depth
);
   import cpc_pkg::*;

   localparam int Lat    = 4 + SqrtCells + 1 + NormalCells + 1;
   localparam int CqLen  = SqrtCells - ContactCells;

   logic             busy_ff;
   logic [Lat-1:0]   vld_ff, vld_in;
   logic             accept;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
      end
   end

   assign vld_in = {vld_ff[Lat-2:0], accept};
   assign busy   = busy_ff;

   // stage 0: capture request
   logic signed [23:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [19:0]        ra_ff, rb_ff;

   always_ff @(posedge clock) begin
      ax_ff <= req_a_x;
      ay_ff <= req_a_y;
      bx_ff <= req_b_x;
      by_ff <= req_b_y;
      ra_ff <= req_a_radius;
      rb_ff <= req_b_radius;
   end

   // stage 1: differences, radius sum, weighted products
   logic signed [24:0] dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic [20:0]        r1_ff, r1_in;
   logic signed [44:0] pxa_ff, pxb_ff, pya_ff, pyb_ff;
   logic signed [44:0] pxa_in, pxb_in, pya_in, pyb_in;

   always_comb begin
      dx1_in = {bx_ff[23], bx_ff} - {ax_ff[23], ax_ff};
      dy1_in = {by_ff[23], by_ff} - {ay_ff[23], ay_ff};
      r1_in  = {1'b0, ra_ff} + {1'b0, rb_ff};
      pxa_in = ax_ff * $signed({1'b0, rb_ff});
      pxb_in = bx_ff * $signed({1'b0, ra_ff});
      pya_in = ay_ff * $signed({1'b0, rb_ff});
      pyb_in = by_ff * $signed({1'b0, ra_ff});
   end

   always_ff @(posedge clock) begin
      dx1_ff <= dx1_in;
      dy1_ff <= dy1_in;
      r1_ff  <= r1_in;
      pxa_ff <= pxa_in;
      pxb_ff <= pxb_in;
      pya_ff <= pya_in;
      pyb_ff <= pyb_in;
   end

   // stage 2: squares and contact numerators
   logic signed [49:0] sqx_full, sqy_full;
   logic [48:0]        sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [41:0]        rr_ff, rr_in;
   logic signed [45:0] numx_ff, numy_ff, numx_in, numy_in;
   logic signed [24:0] dx2_ff, dy2_ff;
   logic [20:0]        r2_ff;

   always_comb begin
      sqx_full = dx1_ff * dx1_ff;
      sqy_full = dy1_ff * dy1_ff;
      sqx_in   = sqx_full[48:0];
      sqy_in   = sqy_full[48:0];
      rr_in    = r1_ff * r1_ff;
      numx_in  = {pxa_ff[44], pxa_ff} + {pxb_ff[44], pxb_ff};
      numy_in  = {pya_ff[44], pya_ff} + {pyb_ff[44], pyb_ff};
   end

   always_ff @(posedge clock) begin
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      rr_ff   <= rr_in;
      numx_ff <= numx_in;
      numy_ff <= numy_in;
      dx2_ff  <= dx1_ff;
      dy2_ff  <= dy1_ff;
      r2_ff   <= r1_ff;
   end

   // stage 3: overlap test, magnitudes, divider operands
   logic [49:0]        d2;
   logic [24:0]        absdx, absdy;
   logic [45:0]        absnx, absny;
   logic [RadicandW-1:0] rad_ff, rad_in;
   side_a_type         sa3_ff, sa3_in;
   logic [45:0]        cnumx_ff, cnumy_ff, cnumx_in, cnumy_in;
   logic [ContactDw-1:0] cden_ff, cden_in;

   always_comb begin
      d2       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      absdx    = dx2_ff[24] ? -dx2_ff : dx2_ff;
      absdy    = dy2_ff[24] ? -dy2_ff : dy2_ff;
      absnx    = numx_ff[45] ? -numx_ff : numx_ff;
      absny    = numy_ff[45] ? -numy_ff : numy_ff;
      rad_in   = {d2[41:0], 20'b0};
      sa3_in.hit    = d2 < {8'b0, rr_ff};
      sa3_in.sx     = dx2_ff[24];
      sa3_in.sy     = dy2_ff[24];
      sa3_in.mx     = absdx[20:0];
      sa3_in.my     = absdy[20:0];
      sa3_in.r      = r2_ff;
      sa3_in.cneg_x = numx_ff[45];
      sa3_in.cneg_y = numy_ff[45];
      // round to nearest: (2m + r) / 2r
      cnumx_in = {absnx[44:0], 1'b0} + {25'b0, r2_ff};
      cnumy_in = {absny[44:0], 1'b0} + {25'b0, r2_ff};
      cden_in  = {r2_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      rad_ff   <= rad_in;
      sa3_ff   <= sa3_in;
      cnumx_ff <= cnumx_in;
      cnumy_ff <= cnumy_in;
      cden_ff  <= cden_in;
   end

   // square root chain
   logic [RadicandW-1:0] sq_rad  [SqrtCells];
   logic [RemW-1:0]      sq_rem  [SqrtCells];
   logic [RootW-1:0]     sq_root [SqrtCells];
   side_a_type           sa_ff   [SqrtCells];

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
      if (i == 0) begin : g_first
         cpc_sqrt_cell u_cell (
            .clock    (clock),
            .src_rad  (rad_ff),
            .src_rem  ('0),
            .src_root ('0),
            .dst_rad  (sq_rad[i]),
            .dst_rem  (sq_rem[i]),
            .dst_root (sq_root[i])
         );
      end else begin : g_next
         cpc_sqrt_cell u_cell (
            .clock    (clock),
            .src_rad  (sq_rad[i-1]),
            .src_rem  (sq_rem[i-1]),
            .src_root (sq_root[i-1]),
            .dst_rad  (sq_rad[i]),
            .dst_rem  (sq_rem[i]),
            .dst_root (sq_root[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      sa_ff[0] <= sa3_ff;
      for (int i = 1; i < SqrtCells; i++) begin
         sa_ff[i] <= sa_ff[i-1];
      end
   end

   // contact divider chains, one per axis
   logic [ContactDw-1:0]    cx_den [ContactCells];
   logic [ContactDw-1:0]    cx_rem [ContactCells];
   logic [ContactCells-1:0] cx_low [ContactCells];
   logic [ContactCells-1:0] cx_quo [ContactCells];
   logic [ContactDw-1:0]    cy_den [ContactCells];
   logic [ContactDw-1:0]    cy_rem [ContactCells];
   logic [ContactCells-1:0] cy_low [ContactCells];
   logic [ContactCells-1:0] cy_quo [ContactCells];

   for (genvar i = 0; i < ContactCells; i++) begin : g_cdiv
      if (i == 0) begin : g_first
         cpc_div_cell #(.DW(ContactDw), .QW(ContactCells)) u_cx (
            .clock   (clock),
            .src_den (cden_ff),
            .src_rem (cnumx_ff[45 -: ContactDw]),
            .src_low (cnumx_ff[ContactCells-1:0]),
            .src_quo ('0),
            .dst_den (cx_den[i]),
            .dst_rem (cx_rem[i]),
            .dst_low (cx_low[i]),
            .dst_quo (cx_quo[i])
         );
         cpc_div_cell #(.DW(ContactDw), .QW(ContactCells)) u_cy (
            .clock   (clock),
            .src_den (cden_ff),
            .src_rem (cnumy_ff[45 -: ContactDw]),
            .src_low (cnumy_ff[ContactCells-1:0]),
            .src_quo ('0),
            .dst_den (cy_den[i]),
            .dst_rem (cy_rem[i]),
            .dst_low (cy_low[i]),
            .dst_quo (cy_quo[i])
         );
      end else begin : g_next
         cpc_div_cell #(.DW(ContactDw), .QW(ContactCells)) u_cx (
            .clock   (clock),
            .src_den (cx_den[i-1]),
            .src_rem (cx_rem[i-1]),
            .src_low (cx_low[i-1]),
            .src_quo (cx_quo[i-1]),
            .dst_den (cx_den[i]),
            .dst_rem (cx_rem[i]),
            .dst_low (cx_low[i]),
            .dst_quo (cx_quo[i])
         );
         cpc_div_cell #(.DW(ContactDw), .QW(ContactCells)) u_cy (
            .clock   (clock),
            .src_den (cy_den[i-1]),
            .src_rem (cy_rem[i-1]),
            .src_low (cy_low[i-1]),
            .src_quo (cy_quo[i-1]),
            .dst_den (cy_den[i]),
            .dst_rem (cy_rem[i]),
            .dst_low (cy_low[i]),
            .dst_quo (cy_quo[i])
         );
      end
   end

   // hold contact quotients until the square root is done
   logic [ContactCells-1:0] cqx_ff [CqLen];
   logic [ContactCells-1:0] cqy_ff [CqLen];

   always_ff @(posedge clock) begin
      cqx_ff[0] <= cx_quo[ContactCells-1];
      cqy_ff[0] <= cy_quo[ContactCells-1];
      for (int i = 1; i < CqLen; i++) begin
         cqx_ff[i] <= cqx_ff[i-1];
         cqy_ff[i] <= cqy_ff[i-1];
      end
   end

   // prep stage: distance, depth, contact sign, normal divider operands
   side_a_type          sa_last;
   logic [RootW-1:0]    h;
   logic [31:0]         hsum;
   logic [21:0]         dist_q8;
   logic [21:0]         dep;
   logic [ContactCells-1:0] qx, qy;
   side_b_type          sb_ff, sb_in;
   logic [46:0]         nnx_ff, nny_ff, nnx_in, nny_in;
   logic [NormalDw-1:0] nden_ff, nden_in;

   always_comb begin
      sa_last = sa_ff[SqrtCells-1];
      h       = sq_root[SqrtCells-1];
      qx      = cqx_ff[CqLen-1];
      qy      = cqy_ff[CqLen-1];
      hsum    = {1'b0, h} + 32'd512;
      dist_q8 = hsum[31:10];
      dep     = {1'b0, sa_last.r} - dist_q8;
      sb_in.hit   = sa_last.hit;
      sb_in.sx    = sa_last.sx;
      sb_in.sy    = sa_last.sy;
      sb_in.nzero = h == '0;
      sb_in.depth = dep[20:0];
      sb_in.cx    = sa_last.cneg_x ? -qx : qx;
      sb_in.cy    = sa_last.cneg_y ? -qy : qy;
      // round to nearest: (2m * 2^24 + h) / 2h
      nnx_in  = {1'b0, sa_last.mx, 25'b0} + {16'b0, h};
      nny_in  = {1'b0, sa_last.my, 25'b0} + {16'b0, h};
      nden_in = {h, 1'b0};
   end

   always_ff @(posedge clock) begin
      sb_ff   <= sb_in;
      nnx_ff  <= nnx_in;
      nny_ff  <= nny_in;
      nden_ff <= nden_in;
   end

   // normal divider chains
   logic [NormalDw-1:0]    nx_den [NormalCells];
   logic [NormalDw-1:0]    nx_rem [NormalCells];
   logic [NormalCells-1:0] nx_low [NormalCells];
   logic [NormalCells-1:0] nx_quo [NormalCells];
   logic [NormalDw-1:0]    ny_den [NormalCells];
   logic [NormalDw-1:0]    ny_rem [NormalCells];
   logic [NormalCells-1:0] ny_low [NormalCells];
   logic [NormalCells-1:0] ny_quo [NormalCells];
   side_b_type             sbd_ff [NormalCells];

   for (genvar i = 0; i < NormalCells; i++) begin : g_ndiv
      if (i == 0) begin : g_first
         cpc_div_cell #(.DW(NormalDw), .QW(NormalCells)) u_nx (
            .clock   (clock),
            .src_den (nden_ff),
            .src_rem (nnx_ff[46 -: NormalDw]),
            .src_low (nnx_ff[NormalCells-1:0]),
            .src_quo ('0),
            .dst_den (nx_den[i]),
            .dst_rem (nx_rem[i]),
            .dst_low (nx_low[i]),
            .dst_quo (nx_quo[i])
         );
         cpc_div_cell #(.DW(NormalDw), .QW(NormalCells)) u_ny (
            .clock   (clock),
            .src_den (nden_ff),
            .src_rem (nny_ff[46 -: NormalDw]),
            .src_low (nny_ff[NormalCells-1:0]),
            .src_quo ('0),
            .dst_den (ny_den[i]),
            .dst_rem (ny_rem[i]),
            .dst_low (ny_low[i]),
            .dst_quo (ny_quo[i])
         );
      end else begin : g_next
         cpc_div_cell #(.DW(NormalDw), .QW(NormalCells)) u_nx (
            .clock   (clock),
            .src_den (nx_den[i-1]),
            .src_rem (nx_rem[i-1]),
            .src_low (nx_low[i-1]),
            .src_quo (nx_quo[i-1]),
            .dst_den (nx_den[i]),
            .dst_rem (nx_rem[i]),
            .dst_low (nx_low[i]),
            .dst_quo (nx_quo[i])
         );
         cpc_div_cell #(.DW(NormalDw), .QW(NormalCells)) u_ny (
            .clock   (clock),
            .src_den (ny_den[i-1]),
            .src_rem (ny_rem[i-1]),
            .src_low (ny_low[i-1]),
            .src_quo (ny_quo[i-1]),
            .dst_den (ny_den[i]),
            .dst_rem (ny_rem[i]),
            .dst_low (ny_low[i]),
            .dst_quo (ny_quo[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      sbd_ff[0] <= sb_ff;
      for (int i = 1; i < NormalCells; i++) begin
         sbd_ff[i] <= sbd_ff[i-1];
      end
   end

   // output register
   side_b_type         sb_last;
   logic [15:0]        qnx, qny;
   logic               hit_ff, hit_in;
   logic signed [23:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [15:0] nxo_ff, nyo_ff, nxo_in, nyo_in;
   logic [20:0]        dep_ff, dep_in;

   always_comb begin
      sb_last = sbd_ff[NormalCells-1];
      qnx     = {1'b0, nx_quo[NormalCells-1]};
      qny     = {1'b0, ny_quo[NormalCells-1]};
      hit_in  = sb_last.hit;
      cx_in   = '0;
      cy_in   = '0;
      nxo_in  = '0;
      nyo_in  = '0;
      dep_in  = '0;
      if (sb_last.hit) begin
         cx_in  = sb_last.cx;
         cy_in  = sb_last.cy;
         dep_in = sb_last.depth;
         // drop the normal for coincident centers
         if (!sb_last.nzero) begin
            nxo_in = sb_last.sx ? -qnx : qnx;
            nyo_in = sb_last.sy ? -qny : qny;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      nxo_ff <= nxo_in;
      nyo_ff <= nyo_in;
      dep_ff <= dep_in;
   end

   assign rsp_valid     = vld_ff[Lat-1];
   assign rsp_hit       = hit_ff;
   assign rsp_contact_x = cx_ff;
   assign rsp_contact_y = cy_ff;
   assign rsp_normal_x  = nxo_ff;
   assign rsp_normal_y  = nyo_ff;
   assign rsp_depth     = dep_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##52 rsp_valid)
      else $error("request did not produce a result after the pipeline depth");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_contact_x == '0 && rsp_contact_y == '0 &&
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_depth == '0))
      else $error("miss result carries nonzero fields");

   a_normal_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384 &&
         rsp_normal_y <= 16'sd16384 && rsp_normal_y >= -16'sd16384))
      else $error("normal component out of unit range");

endmodule
